FILE: hw/rtl/fcer_pkg.sv
// Shared types, constants and fixed-point helpers for the cable row update core.
package fcer_pkg;

   localparam int FRAC_BITS = 24;
   localparam int DATA_W    = 32;
   localparam int SUM_W     = 35;
   localparam int PROD_W    = 64;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] REG_TIME_STEP       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DIFFUSION_GAIN  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_REACTION_GAIN   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD_ALPHA = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_RECOVERY_RATE   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_RECOVERY_DECAY  = 3'd5;

   typedef logic signed [DATA_W-1:0] fix_type;

   localparam fix_type RST_TIME_STEP       = 32'sd1677722;
   localparam fix_type RST_DIFFUSION_GAIN  = 32'sd33554432;
   localparam fix_type RST_REACTION_GAIN   = 32'sd16777216;
   localparam fix_type RST_THRESHOLD_ALPHA = 32'sd1677722;
   localparam fix_type RST_RECOVERY_RATE   = 32'sd83886;
   localparam fix_type RST_RECOVERY_DECAY  = 32'sd33554432;

   localparam fix_type FIX_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam fix_type FIX_MIN = {1'b1, {(DATA_W-1){1'b0}}};
   localparam fix_type FIX_ONE = fix_type'(1) <<< FRAC_BITS;

   typedef struct packed {
      fix_type time_step;
      fix_type diffusion_gain;
      fix_type reaction_gain;
      fix_type threshold_alpha;
      fix_type recovery_rate;
      fix_type recovery_decay;
   } cfg_type;

   // calc: interior update; emit_first/emit_last: boundary results around it
   typedef struct packed {
      logic    calc;
      logic    emit_first;
      logic    emit_last;
      fix_type volt_left;
      fix_type volt_centre;
      fix_type volt_right;
      fix_type recov_centre;
      fix_type recov_first;
      fix_type recov_last;
   } job_type;

   typedef struct packed {
      fix_type val;
      logic    ov;
   } res_type;

   function automatic logic signed [SUM_W-1:0] ext(input fix_type x);
      return SUM_W'(x);
   endfunction

   function automatic res_type sat_sum(input logic signed [SUM_W-1:0] x);
      res_type                 r;
      logic [SUM_W-DATA_W:0]   top;
      top   = x[SUM_W-1:DATA_W-1];
      r.ov  = !((&top) || (~|top));
      r.val = r.ov ? (x[SUM_W-1] ? FIX_MIN : FIX_MAX) : fix_type'(x[DATA_W-1:0]);
      return r;
   endfunction

   // round half up, floor shift, saturate
   function automatic res_type round_sat(input logic signed [PROD_W-1:0] p);
      res_type                                   r;
      logic signed [PROD_W:0]                    q;
      logic [PROD_W-FRAC_BITS-DATA_W+1:0]        top;
      q     = (PROD_W+1)'(p) + ((PROD_W+1)'(1) << (FRAC_BITS-1));
      top   = q[PROD_W:FRAC_BITS+DATA_W-1];
      r.ov  = !((&top) || (~|top));
      r.val = r.ov ? (q[PROD_W] ? FIX_MIN : FIX_MAX)
                   : fix_type'(q[FRAC_BITS+DATA_W-1:FRAC_BITS]);
      return r;
   endfunction

endpackage

FILE: hw/rtl/fcer_front.sv
// Front end: takes cells, keeps the three-cell window and groups the cells into jobs.
module fcer_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [63:0]                req_tdata,   // volt_in [31:0], recov_in [63:32]
   input  logic                       req_tlast,   // row_end_in
   input  logic                       q_full,
   output logic                       q_push,
   output fcer_pkg::job_type          q_job
);
   import fcer_pkg::*;

   localparam logic [1:0] PH_EMPTY = 2'd0;
   localparam logic [1:0] PH_ONE   = 2'd1;
   localparam logic [1:0] PH_TWO   = 2'd2;
   localparam logic [1:0] PH_MORE  = 2'd3;

   logic [1:0] phase_ff, phase_in;
   fix_type    left_ff, left_in;
   fix_type    cvolt_ff, cvolt_in;
   fix_type    crecov_ff, crecov_in;
   fix_type    frecov_ff, frecov_in;
   fix_type    vin, win;
   logic       take;

   assign vin        = fix_type'(req_tdata[31:0]);
   assign win        = fix_type'(req_tdata[63:32]);
   assign req_tready = !q_full;
   assign take       = req_tvalid && !q_full;

   always_comb begin
      phase_in  = phase_ff;
      left_in   = left_ff;
      cvolt_in  = cvolt_ff;
      crecov_in = crecov_ff;
      frecov_in = frecov_ff;
      q_push    = 1'b0;
      q_job.calc         = 1'b0;
      q_job.emit_first   = 1'b0;
      q_job.emit_last    = 1'b0;
      q_job.volt_left    = left_ff;
      q_job.volt_centre  = cvolt_ff;
      q_job.volt_right   = vin;
      q_job.recov_centre = crecov_ff;
      q_job.recov_first  = frecov_ff;
      q_job.recov_last   = win;
      if (take) begin
         case (phase_ff)
            PH_EMPTY: begin
               cvolt_in  = vin;
               crecov_in = win;
               frecov_in = win;
               if (req_tlast) begin
                  q_push          = 1'b1;
                  q_job.emit_last = 1'b1;
               end else begin
                  phase_in = PH_ONE;
               end
            end
            PH_ONE: begin
               if (req_tlast) begin
                  q_push           = 1'b1;
                  q_job.emit_first = 1'b1;
                  q_job.emit_last  = 1'b1;
                  phase_in         = PH_EMPTY;
               end else begin
                  left_in   = cvolt_ff;
                  cvolt_in  = vin;
                  crecov_in = win;
                  phase_in  = PH_TWO;
               end
            end
            default: begin
               q_push           = 1'b1;
               q_job.calc       = 1'b1;
               q_job.emit_first = (phase_ff == PH_TWO) && !req_tlast;
               q_job.emit_last  = req_tlast;
               if (req_tlast) begin
                  phase_in = PH_EMPTY;
               end else begin
                  left_in   = cvolt_ff;
                  cvolt_in  = vin;
                  crecov_in = win;
                  phase_in  = PH_MORE;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_EMPTY;
         left_ff   <= '0;
         cvolt_ff  <= '0;
         crecov_ff <= '0;
         frecov_ff <= '0;
      end else begin
         phase_ff  <= phase_in;
         left_ff   <= left_in;
         cvolt_ff  <= cvolt_in;
         crecov_ff <= crecov_in;
         frecov_ff <= frecov_in;
      end
   end

endmodule

FILE: hw/rtl/fcer_queue.sv
// Job queue between the front end and the arithmetic back end.
module fcer_queue #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  fcer_pkg::job_type   push_job,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output fcer_pkg::job_type   head_job
);
   import fcer_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

FILE: hw/rtl/fcer_back.sv
// Back end: sequenced cell update on one shared multiplier for interior jobs, then result emission.
module fcer_back (
   input  logic                clock,
   input  logic                reset,
   input  fcer_pkg::cfg_type   cfg,
   input  logic                q_valid,
   input  fcer_pkg::job_type   q_job,
   output logic                q_pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [63:0]         rsp_tdata,   // volt_out [31:0], recov_out [63:32]
   output logic                rsp_tlast,   // row_end_out
   output logic [1:0]          rsp_tuser    // overflow_flag [0], run_end [1]
);
   import fcer_pkg::*;

   localparam logic [1:0] BK_IDLE = 2'd0;
   localparam logic [1:0] BK_CALC = 2'd1;
   localparam logic [1:0] BK_EMIT = 2'd2;

   localparam logic [4:0] ST_LAP      = 5'd0;
   localparam logic [4:0] ST_MUL_GAIN = 5'd1;
   localparam logic [4:0] ST_RND_GAIN = 5'd2;
   localparam logic [4:0] ST_MUL_DIFF = 5'd3;
   localparam logic [4:0] ST_RND_DIFF = 5'd4;
   localparam logic [4:0] ST_V1       = 5'd5;
   localparam logic [4:0] ST_RND_AV   = 5'd6;
   localparam logic [4:0] ST_MUL_A    = 5'd7;
   localparam logic [4:0] ST_RND_A    = 5'd8;
   localparam logic [4:0] ST_MUL_B    = 5'd9;
   localparam logic [4:0] ST_RND_R    = 5'd10;
   localparam logic [4:0] ST_F        = 5'd11;
   localparam logic [4:0] ST_MUL_F    = 5'd12;
   localparam logic [4:0] ST_RND_F    = 5'd13;
   localparam logic [4:0] ST_VN       = 5'd14;
   localparam logic [4:0] ST_RND_GW   = 5'd15;
   localparam logic [4:0] ST_G        = 5'd16;
   localparam logic [4:0] ST_RND_DE   = 5'd17;
   localparam logic [4:0] ST_MUL_W    = 5'd18;
   localparam logic [4:0] ST_RND_W    = 5'd19;
   localparam logic [4:0] ST_WN       = 5'd20;

   logic [1:0]               state_ff, state_in;
   logic [4:0]               step_ff, step_in;
   job_type                  job_ff, job_in;
   logic                     pend_first_ff, pend_first_in;
   logic                     pend_mid_ff, pend_mid_in;
   logic                     pend_last_ff, pend_last_in;
   fix_type                  t_ff, t_in;
   fix_type                  a_ff, a_in;
   fix_type                  b_ff, b_in;
   fix_type                  v1_ff, v1_in;
   fix_type                  vn_ff, vn_in;
   fix_type                  wn_ff, wn_in;
   logic                     ov_ff, ov_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   fix_type                  mul_a, mul_b;

   logic                     rsp_valid_ff, rsp_valid_in;
   fix_type                  rsp_volt_ff, rsp_volt_in;
   fix_type                  rsp_recov_ff, rsp_recov_in;
   logic                     rsp_ov_ff, rsp_ov_in;
   logic                     rsp_row_ff, rsp_row_in;
   logic                     rsp_run_ff, rsp_run_in;

   res_type rnd_r, lap_r, om_r, va_r, v1_r, f_r, vn_r, g_r, wn_r;
   logic    out_free;

   assign rnd_r = round_sat(prod_ff);
   assign lap_r = sat_sum(ext(job_ff.volt_left) + ext(job_ff.volt_right)
                          - (ext(job_ff.volt_centre) <<< 1));
   assign om_r  = sat_sum(ext(FIX_ONE) - ext(job_ff.volt_centre));
   assign va_r  = sat_sum(ext(job_ff.volt_centre) - ext(cfg.threshold_alpha));
   assign v1_r  = sat_sum(ext(job_ff.volt_centre) + ext(t_ff));
   assign f_r   = sat_sum(ext(t_ff) - ext(job_ff.recov_centre));
   assign vn_r  = sat_sum(ext(v1_ff) + ext(t_ff));
   assign g_r   = sat_sum(ext(vn_ff) - ext(t_ff));
   assign wn_r  = sat_sum(ext(job_ff.recov_centre) + ext(t_ff));

   always_comb begin
      case (step_ff)
         ST_MUL_GAIN: begin mul_a = cfg.diffusion_gain; mul_b = t_ff; end
         ST_MUL_DIFF: begin mul_a = cfg.time_step;      mul_b = t_ff; end
         ST_V1:       begin mul_a = cfg.reaction_gain;  mul_b = job_ff.volt_centre; end
         ST_MUL_A:    begin mul_a = t_ff;               mul_b = a_ff; end
         ST_MUL_B:    begin mul_a = t_ff;               mul_b = b_ff; end
         ST_MUL_F:    begin mul_a = cfg.time_step;      mul_b = t_ff; end
         ST_VN:       begin mul_a = cfg.recovery_decay; mul_b = job_ff.recov_centre; end
         ST_G:        begin mul_a = cfg.time_step;      mul_b = cfg.recovery_rate; end
         ST_MUL_W:    begin mul_a = a_ff;               mul_b = t_ff; end
         default:     begin mul_a = cfg.time_step;      mul_b = t_ff; end
      endcase
   end

   assign prod_in  = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      job_in        = job_ff;
      pend_first_in = pend_first_ff;
      pend_mid_in   = pend_mid_ff;
      pend_last_in  = pend_last_ff;
      t_in          = t_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      v1_in         = v1_ff;
      vn_in         = vn_ff;
      wn_in         = wn_ff;
      ov_in         = ov_ff;
      q_pop         = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_volt_in   = rsp_volt_ff;
      rsp_recov_in  = rsp_recov_ff;
      rsp_ov_in     = rsp_ov_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_run_in    = rsp_run_ff;
      case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               q_pop         = 1'b1;
               job_in        = q_job;
               pend_first_in = q_job.emit_first;
               pend_mid_in   = q_job.calc;
               pend_last_in  = q_job.emit_last;
               ov_in         = 1'b0;
               step_in       = ST_LAP;
               state_in      = q_job.calc ? BK_CALC : BK_EMIT;
            end
         end
         BK_CALC: begin
            step_in = step_ff + 1'b1;
            case (step_ff)
               ST_LAP: begin
                  t_in  = lap_r.val;
                  a_in  = om_r.val;
                  b_in  = va_r.val;
                  ov_in = ov_ff | lap_r.ov | om_r.ov | va_r.ov;
               end
               ST_RND_GAIN, ST_RND_DIFF, ST_RND_AV, ST_RND_A, ST_RND_R,
               ST_RND_F, ST_RND_GW, ST_RND_W: begin
                  t_in  = rnd_r.val;
                  ov_in = ov_ff | rnd_r.ov;
               end
               ST_V1: begin
                  v1_in = v1_r.val;
                  ov_in = ov_ff | v1_r.ov;
               end
               ST_F: begin
                  t_in  = f_r.val;
                  ov_in = ov_ff | f_r.ov;
               end
               ST_VN: begin
                  vn_in = vn_r.val;
                  ov_in = ov_ff | vn_r.ov;
               end
               ST_G: begin
                  t_in  = g_r.val;
                  ov_in = ov_ff | g_r.ov;
               end
               ST_RND_DE: begin
                  a_in  = rnd_r.val;
                  ov_in = ov_ff | rnd_r.ov;
               end
               ST_WN: begin
                  wn_in    = wn_r.val;
                  ov_in    = ov_ff | wn_r.ov;
                  state_in = BK_EMIT;
               end
               default: begin
               end
            endcase
         end
         BK_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ov_in    = ov_ff;
               if (pend_first_ff) begin
                  rsp_volt_in   = job_ff.calc ? vn_ff : job_ff.volt_centre;
                  rsp_recov_in  = job_ff.recov_first;
                  rsp_row_in    = 1'b0;
                  rsp_run_in    = !(pend_mid_ff || pend_last_ff);
                  pend_first_in = 1'b0;
                  if (!(pend_mid_ff || pend_last_ff)) state_in = BK_IDLE;
               end else if (pend_mid_ff) begin
                  rsp_volt_in  = vn_ff;
                  rsp_recov_in = wn_ff;
                  rsp_row_in   = 1'b0;
                  rsp_run_in   = !pend_last_ff;
                  pend_mid_in  = 1'b0;
                  if (!pend_last_ff) state_in = BK_IDLE;
               end else begin
                  rsp_volt_in  = job_ff.calc ? vn_ff : job_ff.volt_right;
                  rsp_recov_in = job_ff.recov_last;
                  rsp_row_in   = 1'b1;
                  rsp_run_in   = 1'b1;
                  pend_last_in = 1'b0;
                  state_in     = BK_IDLE;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         step_ff       <= ST_LAP;
         pend_first_ff <= 1'b0;
         pend_mid_ff   <= 1'b0;
         pend_last_ff  <= 1'b0;
         ov_ff         <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         pend_first_ff <= pend_first_in;
         pend_mid_ff   <= pend_mid_in;
         pend_last_ff  <= pend_last_in;
         ov_ff         <= ov_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff       <= job_in;
      t_ff         <= t_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      v1_ff        <= v1_in;
      vn_ff        <= vn_in;
      wn_ff        <= wn_in;
      prod_ff      <= prod_in;
      rsp_volt_ff  <= rsp_volt_in;
      rsp_recov_ff <= rsp_recov_in;
      rsp_ov_ff    <= rsp_ov_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_run_ff   <= rsp_run_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_recov_ff, rsp_volt_ff};
   assign rsp_tlast  = rsp_row_ff;
   assign rsp_tuser  = {rsp_run_ff, rsp_ov_ff};

endmodule

FILE: hw/rtl/fhn_cable_euler_row_update_core.sv
// A cell that completes an interior update shows its first result once the update is done; the
// update runs 21 steps on one shared 32x32 multiplier, and the back end takes the next job only
// after the last result of the current one is issued, while boundary-only jobs skip the update.
// The front end keeps accepting cells until the job queue (QUEUE_DEPTH entries) fills.
// Reset (synchronous, active high) restores the register defaults, empties the queue and the
// window, and drops any result in flight.
module fhn_cable_euler_row_update_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [63:0]                       req_tdata,   // volt_in [31:0], recov_in [63:32]
   input  logic                              req_tlast,   // row_end_in
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [63:0]                       rsp_tdata,   // volt_out [31:0], recov_out [63:32]
   output logic                              rsp_tlast,   // row_end_out
   output logic [1:0]                        rsp_tuser,   // overflow_flag [0], run_end [1]
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [fcer_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [31:0]                       csr_data
);
   import fcer_pkg::*;

   cfg_type cfg_ff, cfg_in;
   job_type push_job, head_job;
   logic    q_full, q_push, q_pop, q_valid;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_TIME_STEP:       cfg_in.time_step       = fix_type'(csr_data);
            REG_DIFFUSION_GAIN:  cfg_in.diffusion_gain  = fix_type'(csr_data);
            REG_REACTION_GAIN:   cfg_in.reaction_gain   = fix_type'(csr_data);
            REG_THRESHOLD_ALPHA: cfg_in.threshold_alpha = fix_type'(csr_data);
            REG_RECOVERY_RATE:   cfg_in.recovery_rate   = fix_type'(csr_data);
            REG_RECOVERY_DECAY:  cfg_in.recovery_decay  = fix_type'(csr_data);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.time_step       <= RST_TIME_STEP;
         cfg_ff.diffusion_gain  <= RST_DIFFUSION_GAIN;
         cfg_ff.reaction_gain   <= RST_REACTION_GAIN;
         cfg_ff.threshold_alpha <= RST_THRESHOLD_ALPHA;
         cfg_ff.recovery_rate   <= RST_RECOVERY_RATE;
         cfg_ff.recovery_decay  <= RST_RECOVERY_DECAY;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   fcer_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_job      (push_job)
   );

   fcer_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_job   (push_job),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_job   (head_job)
   );

   fcer_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_job      (head_job),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

FILE: sim/tb_top.sv
// Testbench for the FitzHugh-Nagumo cable row update core: directed table, random rows, scoreboard.
module tb_top;
   import fcer_pkg::*;

   localparam logic [CSR_IDX_W-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_HI = 3'd7;
   localparam int ROW_CELLS_CAP = 256;
   localparam int SETTLE_CYCLES = 40;
   localparam int DRAIN_LIMIT   = 50000;

   typedef struct packed {
      fix_type volt;
      fix_type recov;
      logic    ovf;
      logic    row_end;
      logic    run_end;
   } cell_out_type;

   typedef struct {
      fix_type      volt;
      fix_type      recov;
      bit           last;
      bit           typed;
      int           nt;
      cell_out_type t0;
      cell_out_type t1;
   } dir_row_type;

   typedef enum int {PH_DEFAULT, PH_NOMINAL, PH_MAX, PH_MIN, PH_ZERO, PH_WILD} phase_type;
   typedef enum int {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_mode_type;

   logic                 clock;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [63:0]          req_tdata  = '0;
   logic                 req_tlast  = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [63:0]          rsp_tdata;
   logic                 rsp_tlast;
   logic [1:0]           rsp_tuser;
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [31:0]          csr_data   = '0;

   fhn_cable_euler_row_update_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // predictor state
   cfg_type   coeffs = '{RST_TIME_STEP, RST_DIFFUSION_GAIN, RST_REACTION_GAIN,
                         RST_THRESHOLD_ALPHA, RST_RECOVERY_RATE, RST_RECOVERY_DECAY};
   fix_type   left_v, centre_v, centre_w, first_w;
   int        cells_seen;
   bit        step_ovf;

   cell_out_type next_step_cells[$];
   dir_row_type  dir_cells[$];
   int           fail_count = 0;
   int           burst_left = 0;

   rx_mode_type rx_mode      = RX_OPEN;
   int          rx_mode_left = 0;
   int          rx_tick      = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("FAILURE");
      $finish;
   end

   function automatic longint clip(input longint x);
      if (x > longint'(FIX_MAX)) begin
         step_ovf = 1'b1;
         return longint'(FIX_MAX);
      end
      if (x < longint'(FIX_MIN)) begin
         step_ovf = 1'b1;
         return longint'(FIX_MIN);
      end
      return x;
   endfunction

   // round half up, floor shift, saturate
   function automatic longint qmul(input longint a, input longint b);
      longint p;
      p = a * b + (longint'(1) <<< (FRAC_BITS - 1));
      return clip(p >>> FRAC_BITS);
   endfunction

   task automatic euler_step_cell(input fix_type vin, input fix_type win, input bit last,
                                  output cell_out_type r0, output cell_out_type r1,
                                  output int n);
      longint       dt, lap, v1, a, b, r, f, vn, g, wn;
      cell_out_type res[3];
      int           k;
      k  = 0;
      r0 = '0;
      r1 = '0;
      step_ovf = 1'b0;
      if (cells_seen == 0) begin
         centre_v = vin;
         centre_w = win;
         first_w  = win;
         if (last) begin
            res[k] = '{vin, win, 1'b0, 1'b1, 1'b1};
            k = k + 1;
         end else begin
            cells_seen = 1;
         end
      end else if (cells_seen == 1) begin
         if (last) begin
            res[k] = '{centre_v, first_w, 1'b0, 1'b0, 1'b0};
            k = k + 1;
            res[k] = '{vin, win, 1'b0, 1'b1, 1'b1};
            k = k + 1;
            cells_seen = 0;
         end else begin
            left_v     = centre_v;
            centre_v   = vin;
            centre_w   = win;
            cells_seen = 2;
         end
      end else begin
         dt  = longint'(coeffs.time_step);
         lap = clip(longint'(left_v) + longint'(vin) - 2 * longint'(centre_v));
         v1  = clip(longint'(centre_v) + qmul(dt, qmul(longint'(coeffs.diffusion_gain), lap)));
         a   = clip(longint'(FIX_ONE) - longint'(centre_v));
         b   = clip(longint'(centre_v) - longint'(coeffs.threshold_alpha));
         r   = qmul(qmul(qmul(longint'(coeffs.reaction_gain), longint'(centre_v)), a), b);
         f   = clip(r - longint'(centre_w));
         vn  = clip(v1 + qmul(dt, f));
         g   = clip(vn - qmul(longint'(coeffs.recovery_decay), longint'(centre_w)));
         wn  = clip(longint'(centre_w)
                    + qmul(qmul(dt, longint'(coeffs.recovery_rate)), g));
         if (cells_seen == 2 && !last) begin
            res[k] = '{fix_type'(vn), first_w, step_ovf, 1'b0, 1'b0};
            k = k + 1;
         end
         res[k] = '{fix_type'(vn), fix_type'(wn), step_ovf, 1'b0, !last};
         k = k + 1;
         if (last) begin
            res[k] = '{fix_type'(vn), win, step_ovf, 1'b1, 1'b1};
            k = k + 1;
         end
         if (last) begin
            cells_seen = 0;
         end else begin
            left_v   = centre_v;
            centre_v = vin;
            centre_w = win;
            if (cells_seen < ROW_CELLS_CAP)
               cells_seen++;
         end
      end
      n = k;
      if (k > 0) r0 = res[0];
      if (k > 1) r1 = res[1];
   endtask

   task automatic apply_coeff(input logic [CSR_IDX_W-1:0] idx, input fix_type val);
      case (idx)
         REG_TIME_STEP:       coeffs.time_step       = val;
         REG_DIFFUSION_GAIN:  coeffs.diffusion_gain  = val;
         REG_REACTION_GAIN:   coeffs.reaction_gain   = val;
         REG_THRESHOLD_ALPHA: coeffs.threshold_alpha = val;
         REG_RECOVERY_RATE:   coeffs.recovery_rate   = val;
         REG_RECOVERY_DECAY:  coeffs.recovery_decay  = val;
         default: ;
      endcase
   endtask

   // called at a falling edge, returns at a falling edge
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input fix_type val);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = val;
      do @(posedge clock); while (!csr_ready);
      apply_coeff(idx, val);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic send_cell(input fix_type v, input fix_type w, input bit last,
                            input bit typed, input int nt,
                            input cell_out_type t0, input cell_out_type t1);
      int           gap;
      int           np;
      cell_out_type p0, p1;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
      req_tvalid = 1'b1;
      req_tdata  = {w, v};
      req_tlast  = last;
      do @(posedge clock); while (!req_tready);
      euler_step_cell(v, w, last, p0, p1, np);
      if (typed) begin
         np = nt;
         p0 = t0;
         p1 = t1;
      end
      if (np > 0) next_step_cells.push_back(p0);
      if (np > 1) next_step_cells.push_back(p1);
      burst_left--;
      @(negedge clock);
   endtask

   function automatic fix_type rand_fix();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70)
         return fix_type'(int'($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
      if (pick < 90)
         return fix_type'($urandom);
      case ($urandom_range(0, 4))
         0: return FIX_MAX;
         1: return FIX_MIN;
         2: return '0;
         3: return FIX_ONE;
         default: return -FIX_ONE;
      endcase
   endfunction

   task automatic send_row(input int len);
      for (int i = 0; i < len; i++)
         send_cell(rand_fix(), rand_fix(), i == len - 1, 1'b0, 0, '0, '0);
   endtask

   function automatic fix_type coeff_for(input phase_type ph, input int idx);
      case (ph)
         PH_NOMINAL: begin
            if (idx == int'(REG_TIME_STEP))
               return fix_type'($urandom_range(0, 32'h0080_0000));
            return fix_type'($urandom_range(0, 32'h0200_0000));
         end
         PH_MAX:     return FIX_MAX;
         PH_MIN:     return FIX_MIN;
         PH_ZERO:    return '0;
         default:    return fix_type'($urandom);
      endcase
   endfunction

   // wait until every expected transaction has come back, then let the pipeline go quiet
   task automatic settle();
      int waited;
      waited = 0;
      while (next_step_cells.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (next_step_cells.size() != 0) begin
         $error("%0d expected transactions never arrived", next_step_cells.size());
         fail_count++;
         next_step_cells.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic add_dir(input fix_type v, input fix_type w, input bit last, input bit typed,
                          input int nt, input cell_out_type t0, input cell_out_type t1);
      dir_row_type row;
      row = '{v, w, last, typed, nt, t0, t1};
      dir_cells.push_back(row);
   endtask

   always @(negedge clock) begin
      if (rx_mode_left == 0) begin
         rx_mode      = rx_mode_type'($urandom_range(0, 3));
         rx_mode_left = $urandom_range(20, 200);
      end else begin
         rx_mode_left--;
      end
      rx_tick++;
      case (rx_mode)
         RX_OPEN:   rsp_tready <= 1'b1;
         RX_MOSTLY: rsp_tready <= ($urandom_range(0, 3) != 0);
         RX_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
         default:   rsp_tready <= ((rx_tick % 8) < 5);
      endcase
   end

   always @(posedge clock) begin
      cell_out_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[31:0], rsp_tdata[63:32], rsp_tuser[0], rsp_tlast, rsp_tuser[1]};
         if (next_step_cells.size() == 0) begin
            $error("unexpected transaction: volt_out %h recov_out %h", got.volt, got.recov);
            fail_count++;
         end else begin
            want = next_step_cells.pop_front();
            if (got.volt !== want.volt) begin
               $error("volt_out: expected %h, got %h", want.volt, got.volt);
               fail_count++;
            end
            if (got.recov !== want.recov) begin
               $error("recov_out: expected %h, got %h", want.recov, got.recov);
               fail_count++;
            end
            if (got.ovf !== want.ovf) begin
               $error("overflow_flag: expected %b, got %b", want.ovf, got.ovf);
               fail_count++;
            end
            if (got.row_end !== want.row_end) begin
               $error("row_end_out: expected %b, got %b", want.row_end, got.row_end);
               fail_count++;
            end
            if (got.run_end !== want.run_end) begin
               $error("run_end: expected %b, got %b", want.run_end, got.run_end);
               fail_count++;
            end
         end
      end
   end

   initial begin
      int sent, len;
      left_v     = '0;
      centre_v   = '0;
      centre_w   = '0;
      first_w    = '0;
      cells_seen = 0;

      // one-cell rows pass through
      add_dir(FIX_MAX, FIX_MIN, 1, 1, 1, '{FIX_MAX, FIX_MIN, 1'b0, 1'b1, 1'b1}, '0);
      add_dir('0, '0, 1, 1, 1, '{32'sh0, 32'sh0, 1'b0, 1'b1, 1'b1}, '0);
      // two-cell row passes through
      add_dir(FIX_MIN, FIX_MAX, 0, 1, 0, '0, '0);
      add_dir(32'sh1234_5678, 32'shEDCB_A987, 1, 1, 2,
              '{FIX_MIN, FIX_MAX, 1'b0, 1'b0, 1'b0},
              '{32'sh1234_5678, 32'shEDCB_A987, 1'b0, 1'b1, 1'b1});
      // three-cell row: first boundary dropped
      add_dir(32'sh0080_0000, 32'sh0010_0000, 0, 0, 0, '0, '0);
      add_dir(32'sh0100_0000, -32'sh0020_0000, 0, 0, 0, '0, '0);
      add_dir(32'sh0020_0000, 32'sh0004_0000, 1, 0, 0, '0, '0);
      // short pulse
      add_dir('0, '0, 0, 0, 0, '0, '0);
      add_dir(32'sh0040_0000, 32'sh0001_0000, 0, 0, 0, '0, '0);
      add_dir(FIX_ONE, 32'sh0002_0000, 0, 0, 0, '0, '0);
      add_dir(32'sh0040_0000, -32'sh0001_0000, 0, 0, 0, '0, '0);
      add_dir('0, '0, 1, 0, 0, '0, '0);
      // saturating row
      add_dir(FIX_MAX, FIX_MIN, 0, 0, 0, '0, '0);
      add_dir(FIX_MIN, FIX_MAX, 0, 0, 0, '0, '0);
      add_dir(FIX_MAX, FIX_MIN, 0, 0, 0, '0, '0);
      add_dir(FIX_MIN, FIX_MAX, 0, 0, 0, '0, '0);
      add_dir(FIX_MAX, FIX_MIN, 1, 0, 0, '0, '0);
      // alternating unit values
      add_dir(-FIX_ONE, 32'sh7FFF_0000, 0, 0, 0, '0, '0);
      add_dir(FIX_ONE, -32'sh7FFF_0000, 0, 0, 0, '0, '0);
      add_dir(-FIX_ONE, FIX_ONE, 0, 0, 0, '0, '0);
      add_dir('0, -FIX_ONE, 1, 0, 0, '0, '0);

      repeat (12) @(negedge clock);
      reset = 1'b0;

      foreach (dir_cells[i])
         send_cell(dir_cells[i].volt, dir_cells[i].recov, dir_cells[i].last,
                   dir_cells[i].typed, dir_cells[i].nt, dir_cells[i].t0, dir_cells[i].t1);
      req_tvalid = 1'b0;
      settle();

      for (int ph = int'(PH_DEFAULT); ph <= int'(PH_WILD); ph++) begin
         if (phase_type'(ph) != PH_DEFAULT) begin
            for (int r = int'(REG_TIME_STEP); r <= int'(REG_RECOVERY_DECAY); r++)
               write_reg(CSR_IDX_W'(r), coeff_for(phase_type'(ph), r));
         end
         if (phase_type'(ph) == PH_NOMINAL) write_reg(REG_SPARE_LO, fix_type'($urandom));
         if (phase_type'(ph) == PH_MAX)     write_reg(REG_SPARE_HI, FIX_MAX);
         if (phase_type'(ph) == PH_ZERO)    write_reg(REG_SPARE_HI, fix_type'($urandom));
         // row longer than the cell counter can hold
         if (phase_type'(ph) == PH_DEFAULT) send_row(300);
         sent = 0;
         while (sent < 85) begin
            len = ($urandom_range(0, 99) < 8) ? $urandom_range(1, 2) : $urandom_range(3, 12);
            send_row(len);
            sent += len;
         end
         req_tvalid = 1'b0;
         settle();
      end

      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
